// File: sv/tgad_pkg.sv
// shared types and constants of the tga rle image decoder
package tgad_pkg;

    // result kinds
    localparam logic [1:0] KIND_HEADER = 2'd0;
    localparam logic [1:0] KIND_PIXEL  = 2'd1;
    localparam logic [1:0] KIND_ERROR  = 2'd2;

    // error codes
    localparam logic [1:0] ERR_NONE    = 2'd0;
    localparam logic [1:0] ERR_PATTERN = 2'd1;
    localparam logic [1:0] ERR_DEPTH   = 2'd2;

    // header layout
    localparam logic [4:0] HDR_TYPE_IDX  = 5'd2;
    localparam logic [4:0] HDR_PAT_LEN   = 5'd12;
    localparam logic [4:0] HDR_WIDTH_LO  = 5'd12;
    localparam logic [4:0] HDR_WIDTH_HI  = 5'd13;
    localparam logic [4:0] HDR_HEIGHT_LO = 5'd14;
    localparam logic [4:0] HDR_HEIGHT_HI = 5'd15;
    localparam logic [4:0] HDR_DEPTH_IDX = 5'd16;
    localparam logic [4:0] HDR_LAST_IDX  = 5'd17;

    localparam logic [7:0] TYPE_UNCOMP = 8'h02;
    localparam logic [7:0] TYPE_RLE    = 8'h0A;
    localparam logic [7:0] DEPTH_24    = 8'd24;
    localparam logic [7:0] DEPTH_32    = 8'd32;

    localparam logic [2:0] BPP_NONE = 3'd0;
    localparam logic [2:0] BPP_24   = 3'd3;
    localparam logic [2:0] BPP_32   = 3'd4;

    // pixel unit request: current decode state for one pixel byte
    typedef struct packed {
        logic [7:0]  data;
        logic [1:0]  byte_in_pixel;
        logic [2:0]  depth_bytes;
        logic [23:0] pixel_hold;
        logic        rle_mode;
        logic        packet_is_run;
        logic [7:0]  packet_left;
        logic [31:0] pixels_left;
    } t_pix_req;

    // pixel unit response
    typedef struct packed {
        logic        complete;
        logic [1:0]  byte_in_pixel;
        logic [23:0] pixel_hold;
        logic [7:0]  chan_first;
        logic [7:0]  chan_second;
        logic [7:0]  chan_third;
        logic [7:0]  chan_alpha;
        logic [7:0]  repeat_count;
        logic [7:0]  packet_left;
        logic [31:0] pixels_left;
        logic        packet_done;
        logic        image_done;
    } t_pix_rsp;

endpackage

// File: sv/tgad_pixel.sv
// pixel assembly, channel swap and run-count bookkeeping for one data byte
module tgad_pixel import tgad_pkg::*; (
    input  t_pix_req i_req,
    output t_pix_rsp o_rsp
);

    logic [2:0] next_pos;
    logic [7:0] b0;
    logic [7:0] b2;
    logic [7:0] rep_raw;
    logic [7:0] rep;

    assign next_pos = {1'b0, i_req.byte_in_pixel} + 3'd1;

    always_comb begin
        o_rsp = '0;
        b0 = i_req.pixel_hold[7:0];
        b2 = i_req.pixel_hold[23:16];
        rep_raw = 8'd1;
        rep = 8'd1;
        o_rsp.complete = !((next_pos < i_req.depth_bytes) && (i_req.byte_in_pixel != 2'd3));
        o_rsp.packet_left = i_req.packet_left;
        o_rsp.pixels_left = i_req.pixels_left;
        o_rsp.pixel_hold = i_req.pixel_hold;

        if (!o_rsp.complete) begin
            case (i_req.byte_in_pixel)
                2'd0: o_rsp.pixel_hold[7:0] = i_req.data;
                2'd1: o_rsp.pixel_hold[15:8] = i_req.data;
                2'd2: o_rsp.pixel_hold[23:16] = i_req.data;
                default: o_rsp.pixel_hold = i_req.pixel_hold;
            endcase
            o_rsp.byte_in_pixel = next_pos[1:0];
        end else begin
            // last byte is alpha for 32-bit, else the third channel
            if (i_req.depth_bytes == BPP_32) begin
                o_rsp.chan_alpha = i_req.data;
            end else begin
                b2 = i_req.data;
            end
            o_rsp.chan_second = i_req.pixel_hold[15:8];
            o_rsp.pixel_hold = '0;
            o_rsp.byte_in_pixel = 2'd0;
            if (i_req.rle_mode) begin
                o_rsp.chan_first = b2;
                o_rsp.chan_third = b0;
                if (i_req.packet_is_run) begin
                    rep_raw = i_req.packet_left;
                    o_rsp.packet_left = 8'd0;
                end else if (i_req.packet_left != 8'd0) begin
                    o_rsp.packet_left = i_req.packet_left - 8'd1;
                end
            end else begin
                o_rsp.chan_first = b0;
                o_rsp.chan_third = b2;
            end
            // clamp to the pixels still owed by the image
            rep = (i_req.pixels_left < {24'd0, rep_raw}) ? i_req.pixels_left[7:0] : rep_raw;
            o_rsp.repeat_count = rep;
            o_rsp.pixels_left = i_req.pixels_left - {24'd0, rep};
            o_rsp.packet_done = i_req.rle_mode && (o_rsp.packet_left == 8'd0);
            o_rsp.image_done = (o_rsp.pixels_left == 32'd0);
        end
    end

endmodule

// File: sv/tga_rle_image_decoder_core.sv
// top level of the tga image stream decoder (uncompressed and rle)
//
// input channel: one file byte per request on i_data_byte, with i_file_start
// marking header byte 0 and restarting the parser. i_in_valid / o_in_ready.
// output channel: at most one result per input byte: header, pixel run or
// error, with o_out_valid / i_out_ready.
// the 18-byte header gives a header result or an error on its last byte;
// then each pixel (uncompressed) or rle raw pixel gives one result with
// repeat count 1, and each rle run gives one result with its clamped count.
// a result is registered and shows on the outputs in the cycle after its byte is taken.
// throughput: one byte per cycle unless the receiver stalls; each byte is one pass
// through the parser logic into the state and result registers, one 16x16
// multiply at the header end included.
// when the receiver stalls, the result register holds and o_in_ready drops,
// so no byte is taken until the held result is taken, even a byte that
// would make no result.
// reset (synchronous, active low) puts the parser in the header phase with
// no result pending; after an error or the last pixel, bytes are dropped
// until i_file_start.
module tga_rle_image_decoder_core import tgad_pkg::*; (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_in_valid,
    output logic        o_in_ready,
    input  logic [7:0]  i_data_byte,
    input  logic        i_file_start,
    output logic        o_out_valid,
    input  logic        i_out_ready,
    output logic [1:0]  o_kind,
    output logic [1:0]  o_error_code,
    output logic [15:0] o_image_width,
    output logic [15:0] o_image_height,
    output logic [2:0]  o_bytes_per_pixel,
    output logic [7:0]  o_chan_first,
    output logic [7:0]  o_chan_second,
    output logic [7:0]  o_chan_third,
    output logic [7:0]  o_chan_alpha,
    output logic [7:0]  o_repeat_count,
    output logic        o_last_of_image
);

    typedef enum logic [1:0] {
        PH_HEADER,
        PH_PACKET,
        PH_PIXEL,
        PH_IDLE
    } t_phase;

    t_phase      r_phase, n_phase, cur_phase;
    logic [4:0]  r_hdr_idx, n_hdr_idx, cur_hdr_idx;
    logic        r_hdr_ok, n_hdr_ok, cur_hdr_ok;
    logic        r_rle, n_rle, cur_rle;
    logic [15:0] r_width, n_width, cur_width;
    logic [15:0] r_height, n_height, cur_height;
    logic [2:0]  r_depth, n_depth, cur_depth;
    logic [31:0] r_pixels_left, n_pixels_left, cur_pixels_left;
    logic [7:0]  r_packet_left, n_packet_left, cur_packet_left;
    logic        r_is_run, n_is_run, cur_is_run;
    logic [1:0]  r_bip, n_bip, cur_bip;
    logic [23:0] r_hold, n_hold, cur_hold;

    logic        r_out_valid;
    logic        n_emit;
    logic [1:0]  r_kind, n_kind;
    logic [1:0]  r_err, n_err;
    logic [15:0] r_o_width, n_o_width;
    logic [15:0] r_o_height, n_o_height;
    logic [2:0]  r_bpp, n_bpp;
    logic [7:0]  r_c0, n_c0;
    logic [7:0]  r_c1, n_c1;
    logic [7:0]  r_c2, n_c2;
    logic [7:0]  r_ca, n_ca;
    logic [7:0]  r_rep, n_rep;
    logic        r_last, n_last;

    logic        accept;
    logic        empty_image;
    t_pix_req    pix_req;
    t_pix_rsp    pix_rsp;

    assign o_in_ready = !r_out_valid || i_out_ready;
    assign accept = i_in_valid && o_in_ready;

    // file_start makes this byte see the reset state
    assign cur_phase       = i_file_start ? PH_HEADER : r_phase;
    assign cur_hdr_idx     = i_file_start ? 5'd0 : r_hdr_idx;
    assign cur_hdr_ok      = i_file_start ? 1'b1 : r_hdr_ok;
    assign cur_rle         = i_file_start ? 1'b0 : r_rle;
    assign cur_width       = i_file_start ? 16'd0 : r_width;
    assign cur_height      = i_file_start ? 16'd0 : r_height;
    assign cur_depth       = i_file_start ? BPP_NONE : r_depth;
    assign cur_pixels_left = i_file_start ? 32'd0 : r_pixels_left;
    assign cur_packet_left = i_file_start ? 8'd0 : r_packet_left;
    assign cur_is_run      = i_file_start ? 1'b0 : r_is_run;
    assign cur_bip         = i_file_start ? 2'd0 : r_bip;
    assign cur_hold        = i_file_start ? 24'd0 : r_hold;

    assign empty_image = (cur_width == 16'd0) || (cur_height == 16'd0);

    assign pix_req.data          = i_data_byte;
    assign pix_req.byte_in_pixel = cur_bip;
    assign pix_req.depth_bytes   = cur_depth;
    assign pix_req.pixel_hold    = cur_hold;
    assign pix_req.rle_mode      = cur_rle;
    assign pix_req.packet_is_run = cur_is_run;
    assign pix_req.packet_left   = cur_packet_left;
    assign pix_req.pixels_left   = cur_pixels_left;

    tgad_pixel u_pixel (
        .i_req (pix_req),
        .o_rsp (pix_rsp)
    );

    always_comb begin
        n_phase       = cur_phase;
        n_hdr_idx     = cur_hdr_idx;
        n_hdr_ok      = cur_hdr_ok;
        n_rle         = cur_rle;
        n_width       = cur_width;
        n_height      = cur_height;
        n_depth       = cur_depth;
        n_pixels_left = cur_pixels_left;
        n_packet_left = cur_packet_left;
        n_is_run      = cur_is_run;
        n_bip         = cur_bip;
        n_hold        = cur_hold;
        n_emit        = 1'b0;
        n_kind        = KIND_HEADER;
        n_err         = ERR_NONE;
        n_o_width     = 16'd0;
        n_o_height    = 16'd0;
        n_bpp         = BPP_NONE;
        n_c0          = 8'd0;
        n_c1          = 8'd0;
        n_c2          = 8'd0;
        n_ca          = 8'd0;
        n_rep         = 8'd0;
        n_last        = 1'b0;

        case (cur_phase)
            PH_HEADER: begin
                if (cur_hdr_idx < HDR_PAT_LEN) begin
                    if (cur_hdr_idx == HDR_TYPE_IDX) begin
                        if (i_data_byte == TYPE_UNCOMP) begin
                            n_rle = 1'b0;
                        end else if (i_data_byte == TYPE_RLE) begin
                            n_rle = 1'b1;
                        end else begin
                            n_hdr_ok = 1'b0;
                        end
                    end else if (i_data_byte != 8'd0) begin
                        n_hdr_ok = 1'b0;
                    end
                end else if (cur_hdr_idx == HDR_WIDTH_LO) begin
                    n_width[7:0] = i_data_byte;
                end else if (cur_hdr_idx == HDR_WIDTH_HI) begin
                    n_width[15:8] = i_data_byte;
                end else if (cur_hdr_idx == HDR_HEIGHT_LO) begin
                    n_height[7:0] = i_data_byte;
                end else if (cur_hdr_idx == HDR_HEIGHT_HI) begin
                    n_height[15:8] = i_data_byte;
                end else if (cur_hdr_idx == HDR_DEPTH_IDX) begin
                    n_depth = (i_data_byte == DEPTH_24) ? BPP_24 :
                              ((i_data_byte == DEPTH_32) ? BPP_32 : BPP_NONE);
                end

                if (cur_hdr_idx < HDR_LAST_IDX) begin
                    n_hdr_idx = cur_hdr_idx + 5'd1;
                end else begin
                    n_emit = 1'b1;
                    if (!cur_hdr_ok || (cur_depth == BPP_NONE)) begin
                        n_phase = PH_IDLE;
                        n_kind  = KIND_ERROR;
                        n_err   = cur_hdr_ok ? ERR_DEPTH : ERR_PATTERN;
                    end else begin
                        n_pixels_left = 32'(cur_width) * 32'(cur_height);
                        n_packet_left = 8'd0;
                        n_is_run      = 1'b0;
                        n_bip         = 2'd0;
                        n_hold        = 24'd0;
                        if (empty_image) begin
                            n_phase = PH_IDLE;
                        end else begin
                            n_phase = cur_rle ? PH_PACKET : PH_PIXEL;
                        end
                        n_kind     = KIND_HEADER;
                        n_o_width  = cur_width;
                        n_o_height = cur_height;
                        n_bpp      = cur_depth;
                        n_last     = empty_image;
                    end
                end
            end

            PH_PACKET: begin
                // raw: low bits + 1 pixels; run: low bits + 1 repeats
                n_is_run      = i_data_byte[7];
                n_packet_left = {1'b0, i_data_byte[6:0]} + 8'd1;
                n_bip         = 2'd0;
                n_phase       = PH_PIXEL;
            end

            PH_PIXEL: begin
                n_bip  = pix_rsp.byte_in_pixel;
                n_hold = pix_rsp.pixel_hold;
                if (pix_rsp.complete) begin
                    n_packet_left = pix_rsp.packet_left;
                    n_pixels_left = pix_rsp.pixels_left;
                    if (pix_rsp.image_done) begin
                        n_phase = PH_IDLE;
                    end else if (pix_rsp.packet_done) begin
                        n_phase = PH_PACKET;
                    end
                    n_emit     = 1'b1;
                    n_kind     = KIND_PIXEL;
                    n_o_width  = cur_width;
                    n_o_height = cur_height;
                    n_bpp      = cur_depth;
                    n_c0       = pix_rsp.chan_first;
                    n_c1       = pix_rsp.chan_second;
                    n_c2       = pix_rsp.chan_third;
                    n_ca       = pix_rsp.chan_alpha;
                    n_rep      = pix_rsp.repeat_count;
                    n_last     = pix_rsp.image_done;
                end
            end

            default: begin
                n_phase = cur_phase;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase       <= PH_HEADER;
            r_hdr_idx     <= 5'd0;
            r_hdr_ok      <= 1'b1;
            r_rle         <= 1'b0;
            r_width       <= 16'd0;
            r_height      <= 16'd0;
            r_depth       <= BPP_NONE;
            r_pixels_left <= 32'd0;
            r_packet_left <= 8'd0;
            r_is_run      <= 1'b0;
            r_bip         <= 2'd0;
            r_hold        <= 24'd0;
            r_out_valid   <= 1'b0;
        end else begin
            if (accept) begin
                r_phase       <= n_phase;
                r_hdr_idx     <= n_hdr_idx;
                r_hdr_ok      <= n_hdr_ok;
                r_rle         <= n_rle;
                r_width       <= n_width;
                r_height      <= n_height;
                r_depth       <= n_depth;
                r_pixels_left <= n_pixels_left;
                r_packet_left <= n_packet_left;
                r_is_run      <= n_is_run;
                r_bip         <= n_bip;
                r_hold        <= n_hold;
            end
            if (accept && n_emit) begin
                r_out_valid <= 1'b1;
            end else if (i_out_ready) begin
                r_out_valid <= 1'b0;
            end
        end
        if (accept && n_emit) begin
            r_kind     <= n_kind;
            r_err      <= n_err;
            r_o_width  <= n_o_width;
            r_o_height <= n_o_height;
            r_bpp      <= n_bpp;
            r_c0       <= n_c0;
            r_c1       <= n_c1;
            r_c2       <= n_c2;
            r_ca       <= n_ca;
            r_rep      <= n_rep;
            r_last     <= n_last;
        end
    end

    assign o_out_valid       = r_out_valid;
    assign o_kind            = r_kind;
    assign o_error_code      = r_err;
    assign o_image_width     = r_o_width;
    assign o_image_height    = r_o_height;
    assign o_bytes_per_pixel = r_bpp;
    assign o_chan_first      = r_c0;
    assign o_chan_second     = r_c1;
    assign o_chan_third      = r_c2;
    assign o_chan_alpha      = r_ca;
    assign o_repeat_count    = r_rep;
    assign o_last_of_image   = r_last;

`ifndef NO_ASSERTIONS
    // pixel phases always owe at least one pixel
    a_pixels_owed: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_phase == PH_PIXEL || r_phase == PH_PACKET) |-> (r_pixels_left != 32'd0))
        else $error("pixel phase with no pixels left");

    // byte position stays inside the pixel
    a_byte_pos: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_phase == PH_PIXEL) |-> ({1'b0, r_bip} < r_depth))
        else $error("byte position beyond pixel depth");

    // a pixel result always covers at least one pixel
    a_rep_nonzero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && o_kind == KIND_PIXEL) |-> (o_repeat_count != 8'd0))
        else $error("pixel result with zero repeat count");

    // an error result carries a code and no image fields
    a_error_fields: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && o_kind == KIND_ERROR) |->
            (o_error_code != ERR_NONE && o_image_width == 16'd0 && o_repeat_count == 8'd0))
        else $error("malformed error result");
`endif

endmodule
